@@ rtl/core/linear_probe_hash_table_core_assert.svh @@
// assertion macros for the linear probe hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPHT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpht check failed");
`define LPHT_ASSERT_IMPL(name, clk, rst, cond, conseq) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("lpht implication failed");
`else
`define LPHT_ASSERT(name, clk, rst, prop)
`define LPHT_ASSERT_IMPL(name, clk, rst, cond, conseq)
`endif
`endif

@@ rtl/core/lpht_pkg.sv @@
// shared types, constants and helpers for the hash table core
`default_nettype none
package lpht_pkg;
   localparam int MAX_SLOTS_DEF = 1024;
   localparam int DEFAULT_SIZE = 10;
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int SIZE_REG_W = 11;
   localparam int COUNT_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [SIZE_REG_W-1:0] TABLE_SIZE_RST = 11'd10;
   localparam logic [63:0] HASH_MULT_RST = 64'd2654435761;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXISTS    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE = 2'd0,
      CSR_WIDE_KEYS  = 2'd1,
      CSR_HASH_MULT  = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_DEL_RD, S_DEL_CHK,
      S_MV_HASH, S_MV_RD, S_MV_CHK, S_DONE
   } core_state_type;

   typedef enum logic [2:0] {
      HS_IDLE, HS_MUL0, HS_MUL1, HS_MUL2, HS_SUM, HS_MOD, HS_DONE
   } hash_state_type;

   // narrow keys are sign-extended from their low 32 bits
   function automatic logic [63:0] norm_key(input logic [63:0] key, input logic wide);
      logic [63:0] res;
      if (wide) begin
         res = key;
      end else begin
         res = {{32{key[31]}}, key[31:0]};
      end
      return res;
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/lpht_intf.sv @@
// channel interfaces of the hash table core
`default_nettype none
interface lpht_req_if;
   import lpht_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               operation;
   logic [KEY_W-1:0]         key_bits;
   logic [VAL_W-1:0]         value_bits;
   modport source (output valid, operation, key_bits, value_bits, input ready);
   modport sink (input valid, operation, key_bits, value_bits, output ready);
endinterface

interface lpht_rsp_if;
   import lpht_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [VAL_W-1:0]         found_value;
   logic [COUNT_W-1:0]       entry_count;
   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

interface lpht_csr_if;
   import lpht_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_W-1:0]     index;
   logic [CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lpht_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module lpht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/core/lpht_hash.sv @@
// multiplicative hash and home slot: shared 32x32 multiplier, then bit-serial modulo
`default_nettype none
module lpht_hash #(
   parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [lpht_pkg::KEY_W-1:0]       key,
   input  wire logic                             wide_keys,
   input  wire logic [63:0]                      mult,
   input  wire logic [$clog2(MAX_SLOTS+1)-1:0]   size,
   output logic                                  done,
   output logic [$clog2(MAX_SLOTS)-1:0]          home,
   output logic [$clog2(MAX_SLOTS+1)-1:0]        wrap
);
   import lpht_pkg::*;
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int AW = $clog2(MAX_SLOTS);

   hash_state_type hs_ff, hs_in;
   logic [63:0]    a_ff, a_in;
   logic [63:0]    prod_ff, prod_in;
   logic [63:0]    acc_ff, acc_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  wrap_ff, wrap_in;
   logic [5:0]     bit_ff, bit_in;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    product;
   logic [63:0]    hsum, hneg;
   logic [SW:0]    trial;

   // operand selection for the shared multiplier
   always_comb begin
      case (hs_ff)
         HS_MUL1: begin
            mul_a = a_ff[63:32];
            mul_b = mult[31:0];
         end
         HS_MUL2: begin
            mul_a = a_ff[31:0];
            mul_b = mult[63:32];
         end
         default: begin
            mul_a = a_ff[31:0];
            mul_b = mult[31:0];
         end
      endcase
      product = {32'b0, mul_a} * {32'b0, mul_b};
   end

   // sequencing of products and remainder steps
   always_comb begin
      hs_in   = hs_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      wrap_in = wrap_ff;
      bit_in  = bit_ff;
      done    = 1'b0;
      hsum    = acc_ff + {prod_ff[31:0], 32'b0};
      hneg    = 64'd0 - hsum;
      trial   = {rem_ff, a_ff[63]};
      if (trial >= {1'b0, size}) begin
         trial = trial - {1'b0, size};
      end
      case (hs_ff)
         HS_IDLE: begin
            if (start) begin
               a_in  = norm_key(key, wide_keys);
               hs_in = HS_MUL0;
            end
         end
         HS_MUL0: begin
            prod_in = product;
            hs_in   = HS_MUL1;
         end
         HS_MUL1: begin
            acc_in  = prod_ff;
            prod_in = product;
            hs_in   = HS_MUL2;
         end
         HS_MUL2: begin
            acc_in  = hsum;
            prod_in = product;
            hs_in   = HS_SUM;
         end
         // probe count at which hash plus count rolls over 2^64, zero when out of reach
         HS_SUM: begin
            a_in    = hsum;
            wrap_in = (hneg[63:SW] == '0) ? hneg[SW-1:0] : '0;
            rem_in  = '0;
            bit_in  = 6'd63;
            hs_in   = HS_MOD;
         end
         HS_MOD: begin
            rem_in = trial[SW-1:0];
            a_in   = {a_ff[62:0], 1'b0};
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               hs_in = HS_DONE;
            end
         end
         HS_DONE: begin
            done  = 1'b1;
            hs_in = HS_IDLE;
         end
         default: begin
            hs_in = HS_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff <= HS_IDLE;
      end else begin
         hs_ff <= hs_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      wrap_ff <= wrap_in;
      bit_ff  <= bit_in;
   end

   assign home = rem_ff[AW-1:0];
   assign wrap = wrap_ff;
endmodule
`default_nettype wire

@@ rtl/core/linear_probe_hash_table_core.sv @@
// linear probe hash table core: sequencer around key and value memories
// one operation at a time; hashing a key runs the multiply steps, then 64 remainder steps
// each probe reads memory, then compares; insert and search cost the hash plus their probes
// delete adds, per entry moved after the hole, one re-hash and its own probe run
// clear all and the pass after reset sweep all MAX_SLOTS slots, one slot a cycle, input held off
// synchronous active-high reset restores config defaults and clears control state and the count
`default_nettype none
module linear_probe_hash_table_core #(
   parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   lpht_req_if.sink  req_if,
   lpht_rsp_if.source rsp_if,
   lpht_csr_if.sink  csr_if
);
   import lpht_pkg::*;
`include "linear_probe_hash_table_core_assert.svh"
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int AW = $clog2(MAX_SLOTS);
   localparam int KW = KEY_W + 1;
   localparam logic [SW-1:0] DEF_EFF = SW'((DEFAULT_SIZE > MAX_SLOTS) ? MAX_SLOTS : DEFAULT_SIZE);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);

   // config registers
   logic [SIZE_REG_W-1:0] table_size_ff;
   logic                  wide_ff;
   logic [63:0]           mult_ff;

   core_state_type        state_ff, state_in;
   op_type                op_ff, op_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VAL_W-1:0]      val_ff, val_in;
   logic [AW-1:0]         probe_ff, probe_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         wrap_ff, wrap_in;
   logic [KEY_W-1:0]      mv_key_ff, mv_key_in;
   logic [VAL_W-1:0]      mv_val_ff, mv_val_in;
   logic [AW-1:0]         mv_probe_ff, mv_probe_in;
   logic [SW-1:0]         mv_cnt_ff, mv_cnt_in;
   logic [SW-1:0]         mv_wrap_ff, mv_wrap_in;
   logic [SW-1:0]         occ_ff, occ_in;
   status_type            status_ff, status_in;
   logic [VAL_W-1:0]      found_ff, found_in;
   logic [AW-1:0]         clr_idx_ff, clr_idx_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [SW-1:0]         eff_size;
   logic                  hash_start, hash_done;
   logic [KEY_W-1:0]      hash_key;
   logic [AW-1:0]         hash_home;
   logic [SW-1:0]         hash_wrap;
   logic                  key_we, val_we;
   logic [AW-1:0]         key_waddr, val_waddr, rd_addr;
   logic [KW-1:0]         key_wdata, key_rd;
   logic [VAL_W-1:0]      val_wdata, val_rd;
   logic                  slot_valid, key_match, req_beat;
   logic [SW-1:0]         cnt_next, mv_cnt_next;
   logic [AW-1:0]         probe_next, mv_next;

   // effective size: zero selects the default, large values saturate
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = DEF_EFF;
      end else if (32'(table_size_ff) > MAX_SLOTS) begin
         eff_size = SW'(MAX_SLOTS);
      end else begin
         eff_size = SW'(table_size_ff);
      end
   end

   // config write port
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RST;
         wide_ff       <= 1'b0;
         mult_ff       <= HASH_MULT_RST;
      end else if (csr_if.valid) begin
         case (csr_idx_type'(csr_if.index))
            CSR_TABLE_SIZE: table_size_ff <= csr_if.data[SIZE_REG_W-1:0];
            CSR_WIDE_KEYS:  wide_ff <= csr_if.data[0];
            CSR_HASH_MULT:  mult_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   // key store carries the occupancy mark in its top bit
   lpht_ram #(.WIDTH(KW), .DEPTH(MAX_SLOTS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(rd_addr), .rd_data(key_rd)
   );

   lpht_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SLOTS)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(rd_addr), .rd_data(val_rd)
   );

   lpht_hash #(.MAX_SLOTS(MAX_SLOTS)) u_hash (
      .clock(clock), .reset(reset), .start(hash_start), .key(hash_key),
      .wide_keys(wide_ff), .mult(mult_ff), .size(eff_size),
      .done(hash_done), .home(hash_home), .wrap(hash_wrap)
   );

   // probe helpers; the path restarts at slot zero at the table's end or where hash plus count rolls over
   assign slot_valid  = key_rd[KW-1];
   assign key_match   = norm_key(key_rd[KEY_W-1:0], wide_ff) == norm_key(key_ff, wide_ff);
   assign cnt_next    = cnt_ff + SW'(1);
   assign mv_cnt_next = mv_cnt_ff + SW'(1);
   assign probe_next  = ((cnt_next == wrap_ff) || ((SW'(probe_ff) + SW'(1)) == eff_size))
                        ? '0 : probe_ff + AW'(1);
   assign mv_next     = ((mv_cnt_next == mv_wrap_ff)
                        || ((SW'(mv_probe_ff) + SW'(1)) == eff_size))
                        ? '0 : mv_probe_ff + AW'(1);
   assign rd_addr    = (state_ff == S_MV_RD) ? mv_probe_ff : probe_ff;
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_beat   = req_if.valid && (state_ff == S_IDLE);
   assign hash_key   = (state_ff == S_IDLE) ? req_if.key_bits : key_rd[KEY_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      probe_in      = probe_ff;
      cnt_in        = cnt_ff;
      wrap_in       = wrap_ff;
      mv_key_in     = mv_key_ff;
      mv_val_in     = mv_val_ff;
      mv_probe_in   = mv_probe_ff;
      mv_cnt_in     = mv_cnt_ff;
      mv_wrap_in    = mv_wrap_ff;
      occ_in        = occ_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      clr_idx_in    = clr_idx_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      hash_start    = 1'b0;
      key_we        = 1'b0;
      key_waddr     = probe_ff;
      key_wdata     = {1'b0, key_rd[KEY_W-1:0]};
      val_we        = 1'b0;
      val_waddr     = mv_probe_ff;
      val_wdata     = mv_val_ff;
      case (state_ff)
         // sweep every slot to empty
         S_CLEAR: begin
            key_we     = 1'b1;
            key_waddr  = clr_idx_ff;
            key_wdata  = '0;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == LAST_SLOT) begin
               if (clr_rsp_ff) begin
                  occ_in   = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               op_in    = op_type'(req_if.operation);
               key_in   = req_if.key_bits;
               val_in   = req_if.value_bits;
               found_in = '0;
               cnt_in   = '0;
               if (op_type'(req_if.operation) == OP_CLEAR) begin
                  status_in  = ST_OK;
                  clr_idx_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else begin
                  status_in  = (op_type'(req_if.operation) == OP_INSERT) ? ST_FULL
                                                                         : ST_NOT_FOUND;
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               probe_in = hash_home;
               wrap_in  = hash_wrap;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         // examine one slot on the request key's path
         S_CHK: begin
            if (!slot_valid) begin
               if (op_ff == OP_INSERT) begin
                  key_we    = 1'b1;
                  key_wdata = {1'b1, key_ff};
                  val_we    = 1'b1;
                  val_waddr = probe_ff;
                  val_wdata = val_ff;
                  occ_in    = occ_ff + SW'(1);
                  status_in = ST_OK;
               end
               state_in = S_DONE;
            end else if (key_match) begin
               case (op_ff)
                  OP_INSERT: begin
                     status_in = ST_EXISTS;
                     state_in  = S_DONE;
                  end
                  OP_SEARCH: begin
                     status_in = ST_OK;
                     found_in  = val_rd;
                     state_in  = S_DONE;
                  end
                  default: begin
                     key_we    = 1'b1;
                     status_in = ST_OK;
                     occ_in    = (occ_ff != '0) ? occ_ff - SW'(1) : occ_ff;
                     cnt_in    = cnt_next;
                     probe_in  = probe_next;
                     state_in  = (cnt_next == eff_size) ? S_DONE : S_DEL_RD;
                  end
               endcase
            end else begin
               cnt_in   = cnt_next;
               probe_in = probe_next;
               state_in = (cnt_next == eff_size) ? S_DONE : S_RD;
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_CHK;
         end
         // lift the next entry of the run and re-hash it
         S_DEL_CHK: begin
            if (!slot_valid) begin
               state_in = S_DONE;
            end else begin
               key_we     = 1'b1;
               mv_key_in  = key_rd[KEY_W-1:0];
               mv_val_in  = val_rd;
               hash_start = 1'b1;
               state_in   = S_MV_HASH;
            end
         end
         S_MV_HASH: begin
            if (hash_done) begin
               mv_probe_in = hash_home;
               mv_wrap_in  = hash_wrap;
               mv_cnt_in   = '0;
               state_in    = S_MV_RD;
            end
         end
         S_MV_RD: begin
            state_in = S_MV_CHK;
         end
         // place the lifted entry in the first free slot of its path
         S_MV_CHK: begin
            if (!slot_valid) begin
               key_we    = 1'b1;
               key_waddr = mv_probe_ff;
               key_wdata = {1'b1, mv_key_ff};
               val_we    = 1'b1;
               cnt_in    = cnt_next;
               probe_in  = probe_next;
               state_in  = (cnt_next == eff_size) ? S_DONE : S_DEL_RD;
            end else begin
               mv_cnt_in   = mv_cnt_next;
               mv_probe_in = mv_next;
               state_in    = S_MV_RD;
            end
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_count_in  = COUNT_W'(occ_ff);
               clr_rsp_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      probe_ff      <= probe_in;
      cnt_ff        <= cnt_in;
      wrap_ff       <= wrap_in;
      mv_key_ff     <= mv_key_in;
      mv_val_ff     <= mv_val_in;
      mv_probe_ff   <= mv_probe_in;
      mv_cnt_ff     <= mv_cnt_in;
      mv_wrap_ff    <= mv_wrap_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found_value = rsp_found_ff;
   assign rsp_if.entry_count = rsp_count_ff;

   // checks
   `LPHT_ASSERT(occ_bounded, clock, reset, 32'(occ_ff) <= MAX_SLOTS)
   `LPHT_ASSERT_IMPL(no_write_when_idle, clock, reset, key_we, state_ff != S_IDLE)
   `LPHT_ASSERT_IMPL(hash_done_expected, clock, reset, hash_done,
      (state_ff == S_HASH) || (state_ff == S_MV_HASH))
endmodule
`default_nettype wire
